>>> hdl/vna_pkg.sv
package vna_pkg;

    // Action codes of a request
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TRI  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam int POS_W    = 16;
    localparam int EDGE_W   = POS_W + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int NRM_W    = 16;
    localparam int Q_BITS   = 15;
    localparam int ONE_Q14  = 16384;
    localparam int MUL_LAST = 6;

    typedef struct packed {
        logic [1:0]               action;
        logic [15:0]              vertex_id;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [15:0]              corner_a;
        logic [15:0]              corner_b;
        logic [15:0]              corner_c;
    } t_in_item;

    typedef struct packed {
        logic                     status;
        logic signed [NRM_W-1:0]  normal_x;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [NRM_W-1:0]  normal_z;
    } t_out_item;

endpackage

>>> hdl/vna_stream_if.sv
interface vna_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/vertex_normal_accumulate_unit.sv
// Each action runs its own state sequence from acceptance until its result enters the output register;
// an unknown action or a rejected index goes straight to the finish step.
// Throughput: one request at a time; a triangle is bound by the single position read
// port and the shared 17x17 multiplier, a read by the bit-serial square, root and divide.
// A result waiting in the output register does not block the next request.
// Reset (synchronous, active low) starts a clearing pass over every entry of the
// normal sum memory; no request is taken until it ends.
module vertex_normal_accumulate_unit
    import vna_pkg::*;
#(
    parameter int VERTICES = 1024,
    parameter int SUM_BITS = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vna_stream_if.sink   i_req,
    vna_stream_if.source o_rsp
);

    localparam int IDX_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int SB    = SUM_BITS;
    localparam int CNT_W = $clog2(SB + 1);
    localparam int DIV_W = SB + Q_BITS - 1;
    localparam int PW    = 3 * POS_W;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_TRD, ST_MUL, ST_SRD, ST_SWR,
        ST_RSD, ST_RSQ, ST_SQR, ST_LACC, ST_SQRT, ST_DIV, ST_FIN
    } t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_comp;
    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] r_vid, r_ca, r_cb, r_cc;
    logic [PW-1:0]    r_lpos;

    logic [PW-1:0]    pos_mem [VERTICES];
    logic [3*SB-1:0]  sum_mem [VERTICES];
    logic [PW-1:0]    r_pos_q;
    logic [3*SB-1:0]  r_sum_q;

    logic [PW-1:0]             r_pa, r_pb;
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CROSS_W-1:0] r_cr [3];

    logic [SB-1:0]    r_mag [3];
    logic [2:0]       r_neg;
    logic [SB-1:0]    r_mq;
    logic [2*SB-1:0]  r_acc, r_len2, r_rad;
    logic [SB+1:0]    r_rem;
    logic [SB-1:0]    r_root;
    logic [DIV_W-1:0] r_t, r_d, r_num;
    logic [Q_BITS-1:0] r_q;

    logic                    r_status;
    logic signed [NRM_W-1:0] r_nrm [3];
    logic                    r_ovalid;
    t_out_item               r_odata;

    // Range checks on the incoming request
    logic vid_bad, corner_bad;
    assign vid_bad    = {1'b0, i_req.data.vertex_id} >= 17'(VERTICES);
    assign corner_bad = ({1'b0, i_req.data.corner_a} >= 17'(VERTICES))
                     || ({1'b0, i_req.data.corner_b} >= 17'(VERTICES))
                     || ({1'b0, i_req.data.corner_c} >= 17'(VERTICES));

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    // Corner selection for the sum and position ports
    logic [IDX_W-1:0] n_corner, n_tcorner;
    always_comb begin
        case (r_comp)
            2'd0:    n_corner = r_ca;
            2'd1:    n_corner = r_cb;
            default: n_corner = r_cc;
        endcase
        case (r_cnt[1:0])
            2'd0:    n_tcorner = r_ca;
            2'd1:    n_tcorner = r_cb;
            default: n_tcorner = r_cc;
        endcase
    end

    // Saturating add of a cross product component to a sum
    function automatic logic [SB-1:0] sat_add(input logic [SB-1:0] a,
                                              input logic signed [CROSS_W-1:0] b);
        logic [SB:0] s;
        s = {a[SB-1], a} + {{(SB + 1 - CROSS_W){b[CROSS_W-1]}}, b};
        if (s[SB] != s[SB-1]) begin
            sat_add = s[SB] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
        end else begin
            sat_add = s[SB-1:0];
        end
    endfunction

    // Magnitude of a signed sum
    function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] s);
        mag_of = s[SB-1] ? (~s + SB'(1)) : s;
    endfunction

    // Multiplier operand select and product
    logic signed [EDGE_W-1:0] n_ma, n_mb;
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin n_ma = r_e1[1]; n_mb = r_e2[2]; end
            3'd1:    begin n_ma = r_e1[2]; n_mb = r_e2[1]; end
            3'd2:    begin n_ma = r_e1[2]; n_mb = r_e2[0]; end
            3'd3:    begin n_ma = r_e1[0]; n_mb = r_e2[2]; end
            3'd4:    begin n_ma = r_e1[0]; n_mb = r_e2[1]; end
            default: begin n_ma = r_e1[1]; n_mb = r_e2[0]; end
        endcase
    end
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [CROSS_W-1:0] n_pext;
    assign n_prod = n_ma * n_mb;
    assign n_pext = CROSS_W'(r_prod);

    // Current and next component magnitude
    logic [SB-1:0] n_mag, n_mag_next;
    always_comb begin
        case (r_comp)
            2'd0:    n_mag = r_mag[0];
            2'd1:    n_mag = r_mag[1];
            default: n_mag = r_mag[2];
        endcase
        case (r_comp)
            2'd0:    n_mag_next = r_mag[1];
            default: n_mag_next = r_mag[2];
        endcase
    end

    // Shift-add square, length accumulate
    logic [2*SB-1:0] n_acc, n_len2;
    assign n_acc  = (r_acc << 1) + (r_mq[SB-1] ? (2*SB)'(n_mag) : '0);
    assign n_len2 = r_len2 + r_acc;

    // One root bit per cycle
    logic [SB+1:0] n_rem_t, n_trial;
    logic          n_ge;
    logic [SB-1:0] n_root;
    assign n_rem_t = {r_rem[SB-1:0], r_rad[2*SB-1 -: 2]};
    assign n_trial = {r_root, 2'b01};
    assign n_ge    = n_rem_t >= n_trial;
    assign n_root  = {r_root[SB-2:0], n_ge};

    // One quotient bit per cycle
    logic [DIV_W:0]      n_td;
    logic                n_qb;
    logic [Q_BITS-1:0]   n_q, n_qc;
    logic signed [NRM_W-1:0] n_nrm;
    assign n_td  = {1'b0, r_t} + {1'b0, r_d};
    assign n_qb  = n_td <= {1'b0, r_num};
    assign n_q   = {r_q[Q_BITS-2:0], n_qb};
    assign n_qc  = (n_q > Q_BITS'(ONE_Q14)) ? Q_BITS'(ONE_Q14) : n_q;
    assign n_nrm = r_neg[r_comp] ? -$signed({1'b0, n_qc}) : $signed({1'b0, n_qc});

    // Memory ports
    logic             n_sum_we;
    logic [IDX_W-1:0] n_sum_wa, n_sum_ra, n_pos_ra;
    logic [3*SB-1:0]  n_sum_wd;
    always_comb begin
        n_sum_we = (r_state == ST_CLEAR) || (r_state == ST_LOAD) || (r_state == ST_SWR);
        case (r_state)
            ST_CLEAR: n_sum_wa = r_clr;
            ST_LOAD:  n_sum_wa = r_vid;
            default:  n_sum_wa = n_corner;
        endcase
        if (r_state == ST_SWR) begin
            n_sum_wd = {sat_add(r_sum_q[3*SB-1 -: SB], r_cr[2]),
                        sat_add(r_sum_q[2*SB-1 -: SB], r_cr[1]),
                        sat_add(r_sum_q[SB-1:0], r_cr[0])};
        end else begin
            n_sum_wd = '0;
        end
        n_sum_ra = (r_state == ST_RSD) ? r_vid : n_corner;
        n_pos_ra = n_tcorner;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            pos_mem[r_vid] <= r_lpos;
        end
        r_pos_q <= pos_mem[n_pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (n_sum_we) begin
            sum_mem[n_sum_wa] <= n_sum_wd;
        end
        r_sum_q <= sum_mem[n_sum_ra];
    end

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_comp   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(VERTICES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_vid    <= i_req.data.vertex_id[IDX_W-1:0];
                        r_ca     <= i_req.data.corner_a[IDX_W-1:0];
                        r_cb     <= i_req.data.corner_b[IDX_W-1:0];
                        r_cc     <= i_req.data.corner_c[IDX_W-1:0];
                        r_lpos   <= {i_req.data.pos_z, i_req.data.pos_y, i_req.data.pos_x};
                        r_status <= 1'b0;
                        r_nrm[0] <= '0;
                        r_nrm[1] <= '0;
                        r_nrm[2] <= '0;
                        r_cnt    <= '0;
                        r_comp   <= '0;
                        case (i_req.data.action)
                            ACT_LOAD: begin
                                r_status <= vid_bad;
                                r_state  <= vid_bad ? ST_FIN : ST_LOAD;
                            end
                            ACT_TRI: begin
                                r_status <= corner_bad;
                                r_state  <= corner_bad ? ST_FIN : ST_TRD;
                            end
                            ACT_READ: begin
                                r_status <= vid_bad;
                                r_state  <= vid_bad ? ST_FIN : ST_RSD;
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_LOAD: r_state <= ST_FIN;
                ST_TRD: begin
                    // Fetch the three corner positions, then form the edges
                    r_cnt <= r_cnt + CNT_W'(1);
                    case (r_cnt[1:0])
                        2'd1: r_pa <= r_pos_q;
                        2'd2: r_pb <= r_pos_q;
                        default: ;
                    endcase
                    if (r_cnt[1:0] == 2'd3) begin
                        for (int k = 0; k < 3; k++) begin
                            r_e1[k] <= EDGE_W'($signed(r_pb[k*POS_W +: POS_W]))
                                     - EDGE_W'($signed(r_pa[k*POS_W +: POS_W]));
                            r_e2[k] <= EDGE_W'($signed(r_pos_q[k*POS_W +: POS_W]))
                                     - EDGE_W'($signed(r_pa[k*POS_W +: POS_W]));
                        end
                        r_cnt   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Six products through the shared multiplier, each combined in the cycle after it is formed
                    r_prod <= n_prod;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    case (r_cnt[2:0])
                        3'd1:    r_cr[0] <= n_pext;
                        3'd2:    r_cr[0] <= r_cr[0] - n_pext;
                        3'd3:    r_cr[1] <= n_pext;
                        3'd4:    r_cr[1] <= r_cr[1] - n_pext;
                        3'd5:    r_cr[2] <= n_pext;
                        3'd6:    r_cr[2] <= r_cr[2] - n_pext;
                        default: ;
                    endcase
                    if (r_cnt == CNT_W'(MUL_LAST)) begin
                        r_comp  <= '0;
                        r_state <= ST_SRD;
                    end
                end
                ST_SRD: r_state <= ST_SWR;
                ST_SWR: begin
                    if (r_comp == 2'd2) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= ST_SRD;
                    end
                end
                ST_RSD: r_state <= ST_RSQ;
                ST_RSQ: begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= mag_of(r_sum_q[k*SB +: SB]);
                        r_neg[k] <= r_sum_q[k*SB + SB - 1];
                    end
                    r_mq    <= mag_of(r_sum_q[SB-1:0]);
                    r_acc   <= '0;
                    r_len2  <= '0;
                    r_comp  <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_SQR;
                end
                ST_SQR: begin
                    r_acc <= n_acc;
                    r_mq  <= r_mq << 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SB - 1)) begin
                        r_state <= ST_LACC;
                    end
                end
                ST_LACC: begin
                    r_len2 <= n_len2;
                    r_cnt  <= '0;
                    if (r_comp == 2'd2) begin
                        r_rad   <= n_len2;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_acc   <= '0;
                        r_mq    <= n_mag_next;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQRT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= n_ge ? (n_rem_t - n_trial) : n_rem_t;
                    r_root <= n_root;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SB - 1)) begin
                        r_cnt  <= '0;
                        r_comp <= '0;
                        r_t    <= '0;
                        r_q    <= '0;
                        r_d    <= {n_root, {(Q_BITS - 1){1'b0}}};
                        r_num  <= {r_mag[0], {(Q_BITS - 1){1'b0}}};
                        r_state <= (n_root == '0) ? ST_FIN : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (n_qb) begin
                        r_t <= n_td[DIV_W-1:0];
                    end
                    r_q   <= n_q;
                    r_d   <= r_d >> 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(Q_BITS - 1)) begin
                        r_nrm[r_comp] <= n_nrm;
                        r_cnt <= '0;
                        r_t   <= '0;
                        r_q   <= '0;
                        r_d   <= {r_root, {(Q_BITS - 1){1'b0}}};
                        r_num <= {n_mag_next, {(Q_BITS - 1){1'b0}}};
                        if (r_comp == 2'd2) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end
                ST_FIN: begin
                    // Hand the result over once the output register is free
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid         <= 1'b1;
                        r_odata.status   <= r_status;
                        r_odata.normal_x <= r_nrm[0];
                        r_odata.normal_y <= r_nrm[1];
                        r_odata.normal_z <= r_nrm[2];
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_req.ready)
        else $error("request taken during clearing pass");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("ready after accepting a request");

    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status) |->
        (o_rsp.data.normal_x == '0 && o_rsp.data.normal_y == '0
         && o_rsp.data.normal_z == '0))
        else $error("nonzero normal on a rejected request");

    a_result_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid)) |-> ($past(r_state) == ST_FIN))
        else $error("result loaded outside the finish step");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
    import vna_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERT   = 1024;
    localparam int ACC_BITS   = 48;
    localparam int WDOG_LIMIT = 40000;
    localparam int RAND_ITEMS = 1330;
    localparam int POOL       = 24;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Normal accumulation predictor and queue of expected responses
    class normal_scoreboard;
        logic signed [15:0] pos_mem [NUM_VERT][3];
        logic signed [63:0] acc_mem [NUM_VERT][3];
        t_out_item          pending_rsp [$];
        int                 mismatches;
        int                 checked;

        function new();
            for (int v = 0; v < NUM_VERT; v++) begin
                for (int k = 0; k < 3; k++) begin
                    pos_mem[v][k] = '0;
                    acc_mem[v][k] = '0;
                end
            end
            mismatches = 0;
            checked = 0;
        endfunction

        function logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] hi;
            logic signed [63:0] lo;
            logic signed [64:0] s;
            hi = (64'sd1 <<< (ACC_BITS - 1)) - 1;
            lo = -hi - 1;
            s = a + b;
            if (s > hi) return hi;
            if (s < lo) return lo;
            return s[63:0];
        endfunction

        function logic [63:0] isqrt(logic [127:0] n);
            logic [63:0] r;
            logic [63:0] c;
            r = '0;
            for (int i = 63; i >= 0; i--) begin
                c = r | (64'd1 << i);
                if (128'(c) * 128'(c) <= n) r = c;
            end
            return r;
        endfunction

        function logic signed [15:0] unit_comp(logic signed [63:0] s, logic [63:0] len);
            logic [63:0]  mag;
            logic [127:0] q;
            mag = s < 0 ? -s : s;
            q = (128'(mag) * 128'(ONE_Q14)) / 128'(len);
            if (q > ONE_Q14) q = ONE_Q14;
            return s < 0 ? -16'(q) : 16'(q);
        endfunction

        // Apply one accepted request and queue its response
        function void note_request(t_in_item r);
            t_out_item o;
            logic signed [63:0] e1 [3];
            logic signed [63:0] e2 [3];
            logic signed [63:0] cr [3];
            logic [63:0]  m;
            logic [127:0] len2;
            logic [63:0]  len;
            int           cn [3];
            o = '0;
            case (r.action)
                ACT_LOAD: begin
                    if (r.vertex_id >= NUM_VERT) begin
                        o.status = 1'b1;
                    end else begin
                        pos_mem[r.vertex_id][0] = r.pos_x;
                        pos_mem[r.vertex_id][1] = r.pos_y;
                        pos_mem[r.vertex_id][2] = r.pos_z;
                        for (int k = 0; k < 3; k++) acc_mem[r.vertex_id][k] = '0;
                    end
                end
                ACT_TRI: begin
                    if (r.corner_a >= NUM_VERT || r.corner_b >= NUM_VERT ||
                        r.corner_c >= NUM_VERT) begin
                        o.status = 1'b1;
                    end else begin
                        cn[0] = r.corner_a;
                        cn[1] = r.corner_b;
                        cn[2] = r.corner_c;
                        for (int k = 0; k < 3; k++) begin
                            e1[k] = 64'(pos_mem[cn[1]][k]) - 64'(pos_mem[cn[0]][k]);
                            e2[k] = 64'(pos_mem[cn[2]][k]) - 64'(pos_mem[cn[0]][k]);
                        end
                        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                        for (int j = 0; j < 3; j++)
                            for (int k = 0; k < 3; k++)
                                acc_mem[cn[j]][k] = clamp_add(acc_mem[cn[j]][k], cr[k]);
                    end
                end
                ACT_READ: begin
                    if (r.vertex_id >= NUM_VERT) begin
                        o.status = 1'b1;
                    end else begin
                        len2 = '0;
                        for (int k = 0; k < 3; k++) begin
                            m = acc_mem[r.vertex_id][k] < 0 ?
                                -acc_mem[r.vertex_id][k] : acc_mem[r.vertex_id][k];
                            len2 += 128'(m) * 128'(m);
                        end
                        len = isqrt(len2);
                        if (len != 0) begin
                            o.normal_x = unit_comp(acc_mem[r.vertex_id][0], len);
                            o.normal_y = unit_comp(acc_mem[r.vertex_id][1], len);
                            o.normal_z = unit_comp(acc_mem[r.vertex_id][2], len);
                        end
                    end
                end
                default: ;
            endcase
            pending_rsp.push_back(o);
        endfunction

        // Compare one response with the oldest expectation
        function void check_response(t_out_item got);
            t_out_item want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response %h", $realtime, got);
                mismatches++;
                return;
            end
            want = pending_rsp.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                mismatches++;
            end
            if (got.normal_x !== want.normal_x) begin
                $display("%0t: normal_x exp %0d got %0d", $realtime, want.normal_x, got.normal_x);
                mismatches++;
            end
            if (got.normal_y !== want.normal_y) begin
                $display("%0t: normal_y exp %0d got %0d", $realtime, want.normal_y, got.normal_y);
                mismatches++;
            end
            if (got.normal_z !== want.normal_z) begin
                $display("%0t: normal_z exp %0d got %0d", $realtime, want.normal_z, got.normal_z);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    vna_stream_if #(.t_payload(t_in_item))  req_if ();
    vna_stream_if #(.t_payload(t_out_item)) rsp_if ();

    vertex_normal_accumulate_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    normal_scoreboard normals = new();

    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_cycles;
    int  sent_count;
    bit  loaded [NUM_VERT];
    int  loaded_ids [$];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Randomly stall the response side
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Score accepted requests and responses; watch for a hang
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (req_if.valid && req_if.ready) normals.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready) normals.check_response(rsp_if.data);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t: watchdog expired", $realtime);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted; drop valid while idling
    task automatic send_request(t_in_item r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (r.action == ACT_LOAD && r.vertex_id < NUM_VERT && !loaded[r.vertex_id]) begin
            loaded[r.vertex_id] = 1'b1;
            loaded_ids.push_back(r.vertex_id);
        end
        sent_count++;
    endtask

    function automatic t_in_item make_req(logic [1:0] act, logic [15:0] vid,
                                          logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                          logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
        t_in_item r;
        r.action = act;
        r.vertex_id = vid;
        r.pos_x = px;
        r.pos_y = py;
        r.pos_z = pz;
        r.corner_a = ca;
        r.corner_b = cb;
        r.corner_c = cc;
        return r;
    endfunction

    function automatic logic [15:0] pick_loaded();
        return 16'(loaded_ids[$urandom_range(loaded_ids.size() - 1)]);
    endfunction

    // Random vertex id: mostly a small pool, sometimes anywhere, rarely out of range
    function automatic logic [15:0] pick_vertex();
        int p;
        p = $urandom_range(99);
        if (p < 75) return 16'($urandom_range(POOL - 1));
        if (p < 92) return 16'($urandom_range(NUM_VERT - 1));
        return 16'($urandom_range(16'hFFFF, NUM_VERT));
    endfunction

    function automatic logic [15:0] rand_coord();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 16'h8000;
        if (p == 1) return 16'h7FFF;
        if (p < 5) return 16'($signed($urandom_range(200)) - 100);
        return 16'($urandom);
    endfunction

    // Corner for a triangle: loaded vertex, or out of range now and then
    function automatic logic [15:0] pick_corner(bit allow_bad);
        if (allow_bad && $urandom_range(99) < 4) return 16'($urandom_range(16'hFFFF, NUM_VERT));
        return pick_loaded();
    endfunction

    task automatic send_random();
        int p;
        logic [15:0] v;
        t_in_item r;
        p = $urandom_range(99);
        if (p < 25) begin
            r = make_req(ACT_LOAD, pick_vertex(), rand_coord(), rand_coord(), rand_coord(),
                         16'($urandom), 16'($urandom), 16'($urandom));
        end else if (p < 70) begin
            r = make_req(ACT_TRI, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), pick_corner(1), pick_corner(1), pick_corner(1));
        end else if (p < 97) begin
            // Read loaded vertices or out-of-range ids only
            v = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF, NUM_VERT))
                                         : pick_loaded();
            r = make_req(ACT_READ, v, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            r = make_req(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        send_request(r);
    endtask

    // Drop valid and hold until every expected response is back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (normals.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent_count = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every action, corner cases
        send_idle_pct = 16;
        recv_idle_pct = 83;
        send_request(make_req(ACT_LOAD, 16'd0, 16'h8000, 16'h8000, 16'h8000,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(make_req(ACT_LOAD, 16'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0));
        send_request(make_req(ACT_LOAD, 16'd2, 16'h8000, 16'h7FFF, 16'h7FFF, 0, 0, 0));
        send_request(make_req(ACT_LOAD, 16'(NUM_VERT - 1), 16'h7FFF, 16'h7FFF, 16'h8000,
                              0, 0, 0));
        send_request(make_req(ACT_LOAD, 16'(NUM_VERT), 16'h1234, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_LOAD, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        // Zero length before any triangle
        send_request(make_req(ACT_READ, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(make_req(ACT_TRI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'd0, 16'd1, 16'd2));
        send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'd1, 16'd2, 16'(NUM_VERT - 1)));
        send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'(NUM_VERT), 16'd1, 16'd2));
        send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'd0, 16'hFFFF, 16'd2));
        send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'd0, 16'd1, 16'hFFFF));
        // Degenerate triangle adds nothing
        send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'd0, 16'd0, 16'd1));
        send_request(make_req(ACT_READ, 16'd0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'd1, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'(NUM_VERT - 1), 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'(NUM_VERT), 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_READ, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_request(make_req(ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
        // Drive vertex 0 toward saturation with the largest triangle
        for (int i = 0; i < 4; i++)
            send_request(make_req(ACT_TRI, 0, 0, 0, 0, 16'd0, 16'd1, 16'd2));
        send_request(make_req(ACT_READ, 16'd0, 0, 0, 0, 0, 0, 0));

        // Pause until every response is back
        wait_drained();

        // Seed the pool so random triangles have loaded corners
        for (int v = 0; v < POOL; v++)
            send_request(make_req(ACT_LOAD, 16'(v), rand_coord(), rand_coord(), rand_coord(),
                                  0, 0, 0));

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 16;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random();
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Sent %0d requests (loads, triangles, reads, invalid ids, unknown actions);",
                 sent_count);
        $display("checked %0d responses under three stall mixes.", normals.checked);
        if (normals.mismatches == 0 && normals.pending_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
